>>> rtl/otua_pkg.sv
package otua_pkg;

    localparam int MAX_UNITS  = 16;
    localparam int OWNER_BITS = 16;

    // field widths fixed by the interface
    localparam int OWNER_FIELD_W = 16;
    localparam int COUNT_FIELD_W = 5;

    // stored owner width: ids are masked to OWNER_BITS, never wider than the field
    localparam int OWN_W = (OWNER_BITS < OWNER_FIELD_W) ? OWNER_BITS : OWNER_FIELD_W;
    // counts run 0..MAX_UNITS
    localparam int CNT_W = $clog2(MAX_UNITS + 1);
    localparam int IDX_W = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;

    localparam int RESET_UNITS = (MAX_UNITS < 16) ? MAX_UNITS : 16;

    localparam logic CMD_REQUEST = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } seq_state_t;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [OWN_W-1:0] wr_data;
        logic             clear;
    } ram_req_t;

    typedef struct packed {
        logic [OWN_W-1:0] data;
        logic             valid;
    } ram_rsp_t;

    typedef struct packed {
        logic             valid;
        logic             success;
        logic [CNT_W-1:0] free;
    } seq_res_t;

endpackage

>>> rtl/otua_cmd_if.sv
interface otua_cmd_if;
    import otua_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     command;
    logic [OWNER_FIELD_W-1:0] owner_id;
    logic [COUNT_FIELD_W-1:0] unit_request;

    modport source (output valid, output command, output owner_id, output unit_request,
                    input ready);
    modport sink   (input valid, input command, input owner_id, input unit_request,
                    output ready);
endinterface

>>> rtl/otua_rsp_if.sv
interface otua_rsp_if;
    import otua_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     success;
    logic [COUNT_FIELD_W-1:0] free_units;

    modport source (output valid, output success, output free_units, input ready);
    modport sink   (input valid, input success, input free_units, output ready);
endinterface

>>> rtl/otua_cfg_if.sv
interface otua_cfg_if;
    import otua_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [COUNT_FIELD_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/otua_slot_ram.sv
module otua_slot_ram
    import otua_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  ram_req_t req,
    output ram_rsp_t rsp
);

    logic [OWN_W-1:0]     slot_mem [MAX_UNITS];
    logic [MAX_UNITS-1:0] valid_reg;
    logic [OWN_W-1:0]     rd_data_reg;
    logic                 rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            slot_mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg  <= slot_mem[req.rd_addr];
            rd_valid_reg <= valid_reg[req.rd_addr];
        end
    end

    // entry without a valid bit reads as a free slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (req.clear)
        begin
            valid_reg <= '0;
        end
        else if (req.wr_en)
        begin
            valid_reg[req.wr_addr] <= 1'b1;
        end
    end

    assign rsp.data  = rd_data_reg;
    assign rsp.valid = rd_valid_reg;

endmodule

>>> rtl/otua_scan_seq.sv
module otua_scan_seq
    import otua_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    otua_cmd_if.sink         cmd,
    input  logic             cfg_wr,
    input  logic [CNT_W-1:0] cfg_count,
    input  logic [CNT_W-1:0] unit_count,
    output seq_res_t         res,
    input  logic             res_ready,
    output ram_req_t         ram_req,
    input  ram_rsp_t         ram_rsp
);

    seq_state_t state_reg, state_next;

    logic                     cmd_reg, cmd_next;
    logic [OWN_W-1:0]         owner_reg, owner_next;
    logic [COUNT_FIELD_W-1:0] want_reg, want_next;
    logic [CNT_W-1:0]         idx_reg, idx_next;
    logic                     chk_reg, chk_next;
    logic [IDX_W-1:0]         chk_idx_reg, chk_idx_next;
    logic [CNT_W-1:0]         got_reg, got_next;
    logic                     ok_reg, ok_next;
    logic [CNT_W-1:0]         free_count_reg, free_count_next;

    logic             accept;
    logic             go_scan;
    logic             issue;
    logic             hit;
    logic             scan_end;
    logic [OWN_W-1:0] slot;
    logic [OWN_W-1:0] in_owner;

    assign accept   = cmd.valid && cmd.ready;
    assign in_owner = cmd.owner_id[OWN_W-1:0];
    assign issue    = (state_reg == ST_SCAN) && (32'(idx_reg) < 32'(unit_count));
    assign scan_end = !issue && !chk_reg;
    assign slot     = ram_rsp.valid ? ram_rsp.data : '0;

    // shared compare unit: one slot per cycle, compared in the cycle after its read
    always_comb
    begin
        hit = 1'b0;
        if (state_reg == ST_SCAN && chk_reg)
        begin
            if (cmd_reg == CMD_REQUEST)
            begin
                hit = (slot == '0) && (32'(got_reg) < 32'(want_reg));
            end
            else
            begin
                hit = (slot == owner_reg);
            end
        end
    end

    always_comb
    begin
        if (cmd.command == CMD_REQUEST)
        begin
            go_scan = (in_owner != '0) && (cmd.unit_request != '0)
                   && (32'(free_count_reg) >= 32'(cmd.unit_request));
        end
        else
        begin
            go_scan = (in_owner != '0);
        end
    end

    always_comb
    begin
        cmd_next        = cmd_reg;
        owner_next      = owner_reg;
        want_next       = want_reg;
        idx_next        = idx_reg;
        chk_next        = 1'b0;
        chk_idx_next    = chk_idx_reg;
        got_next        = got_reg;
        ok_next         = ok_reg;
        free_count_next = free_count_reg;

        if (cfg_wr)
        begin
            free_count_next = cfg_count;
        end

        if (accept)
        begin
            cmd_next   = cmd.command;
            owner_next = in_owner;
            want_next  = cmd.unit_request;
            idx_next   = '0;
            got_next   = '0;
            if (cmd.command == CMD_REQUEST)
            begin
                ok_next = (in_owner != '0)
                       && (32'(free_count_reg) >= 32'(cmd.unit_request));
            end
            else
            begin
                ok_next = 1'b0;
            end
        end

        if (issue)
        begin
            idx_next     = idx_reg + 1'b1;
            chk_next     = 1'b1;
            chk_idx_next = idx_reg[IDX_W-1:0];
        end

        if (hit)
        begin
            if (cmd_reg == CMD_REQUEST)
            begin
                got_next        = got_reg + 1'b1;
                free_count_next = free_count_reg - 1'b1;
            end
            else
            begin
                free_count_next = free_count_reg + 1'b1;
                ok_next         = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = go_scan ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.ready       = 1'b0;
        res.valid       = 1'b0;
        res.success     = ok_reg;
        res.free        = free_count_reg;
        ram_req.rd_en   = issue;
        ram_req.rd_addr = idx_reg[IDX_W-1:0];
        ram_req.wr_en   = hit;
        ram_req.wr_addr = chk_idx_reg;
        ram_req.wr_data = (cmd_reg == CMD_REQUEST) ? owner_reg : '0;
        ram_req.clear   = cfg_wr;
        unique case (state_reg)
            ST_IDLE: cmd.ready = 1'b1;
            ST_SCAN: ;
            ST_DONE: res.valid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            chk_reg        <= 1'b0;
            free_count_reg <= CNT_W'(RESET_UNITS);
        end
        else
        begin
            state_reg      <= state_next;
            chk_reg        <= chk_next;
            free_count_reg <= free_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        owner_reg   <= owner_next;
        want_reg    <= want_next;
        idx_reg     <= idx_next;
        chk_idx_reg <= chk_idx_next;
        got_reg     <= got_next;
        ok_reg      <= ok_next;
    end

endmodule

>>> rtl/owner_tagged_unit_allocator_unit.sv
// Channel  Dir  Payload                           Transfer
// cmd      in   command, owner_id, unit_request   valid && ready
// rsp      out  success, free_units               valid && ready
// cfg      in   data (unit_count)                 valid && ready
//
// One item at a time. Early-out cases (owner zero, short pool, zero count)
// go from the cmd transfer straight to the done state; a slot scan walks the
// pool slot by slot through the single slot-compare unit and the registered
// slot memory read (one slot per cycle).
// Reset clears all tags at once through per-slot valid bits; no sweep.
// A waiting result sits in the output register; cmd is taken again once
// the sequencer has handed its result over.
module owner_tagged_unit_allocator_unit
    import otua_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    otua_cmd_if.sink cmd,
    otua_rsp_if.source rsp,
    otua_cfg_if.sink cfg
);

    logic [CNT_W-1:0]         unit_count_reg;
    logic [CNT_W-1:0]         cfg_count;
    logic                     cfg_wr;
    logic                     rsp_valid_reg;
    logic                     success_reg;
    logic [COUNT_FIELD_W-1:0] free_units_reg;
    logic                     res_ready;
    seq_res_t                 res;
    ram_req_t                 ram_req;
    ram_rsp_t                 ram_rsp;

    assign cfg.ready = 1'b1;
    assign cfg_wr    = cfg.valid && cfg.ready;
    // oversized pool sizes clamp to the physical slot count
    assign cfg_count = (32'(cfg.data) > 32'(MAX_UNITS)) ? CNT_W'(MAX_UNITS) : CNT_W'(cfg.data);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_count_reg <= CNT_W'(RESET_UNITS);
        end
        else if (cfg_wr)
        begin
            unit_count_reg <= cfg_count;
        end
    end

    otua_scan_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .cfg_wr     (cfg_wr),
        .cfg_count  (cfg_count),
        .unit_count (unit_count_reg),
        .res        (res),
        .res_ready  (res_ready),
        .ram_req    (ram_req),
        .ram_rsp    (ram_rsp)
    );

    otua_slot_ram u_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ram_req),
        .rsp   (ram_rsp)
    );

    assign res_ready = !rsp_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            rsp_valid_reg <= res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid && res_ready)
        begin
            success_reg    <= res.success;
            free_units_reg <= COUNT_FIELD_W'(res.free);
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.success    = success_reg;
    assign rsp.free_units = free_units_reg;

`ifndef ASSERT_OFF
    a_free_le_units: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (32'(rsp.free_units) <= 32'(unit_count_reg)))
        else $error("free count above pool size");

    a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready) |=> !cmd.ready)
        else $error("command taken while a command is in flight");

    a_res_held: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res_ready) |=> (res.valid && $stable(res.free) && $stable(res.success)))
        else $error("sequencer result dropped while output register full");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ready |-> !ram_req.wr_en)
        else $error("slot write outside a scan");
`endif

endmodule

>>> tb/tb_owner_tagged_unit_allocator_unit.sv
`timescale 1ns / 1ps

module tb_owner_tagged_unit_allocator_unit;
    import otua_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int SETTLE       = 25;
    localparam int QUIET_FROM   = 8000;
    localparam int QUIET_TO     = 14000;

    typedef struct packed {
        logic                     command;
        logic [OWNER_FIELD_W-1:0] owner;
        logic [COUNT_FIELD_W-1:0] want;
    } alloc_op_t;

    typedef struct packed {
        logic                     success;
        logic [COUNT_FIELD_W-1:0] free_units;
    } alloc_res_t;

    logic clk = 1'b0;
    logic rst_n;

    otua_cmd_if cmd();
    otua_rsp_if rsp();
    otua_cfg_if cfg();

    owner_tagged_unit_allocator_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow of the pool
    logic [OWN_W-1:0] slot_tag [MAX_UNITS];
    int               pool_size;
    int               free_left;

    alloc_op_t  op_q[$];
    alloc_res_t grant_q[$];
    bit         cmd_fired;
    int         hold_off;
    int         cyc;
    int         err_cnt;

    function automatic void pool_resize(input logic [COUNT_FIELD_W-1:0] units);
        pool_size = (units > MAX_UNITS) ? MAX_UNITS : units;
        foreach (slot_tag[k])
            slot_tag[k] = '0;
        free_left = pool_size;
    endfunction

    function automatic alloc_res_t apply_op(input alloc_op_t op);
        alloc_res_t       res;
        logic [OWN_W-1:0] who;
        int               taken;
        who = op.owner[OWN_W-1:0];
        res.success = 1'b0;
        taken = 0;
        if (op.command == CMD_REQUEST)
        begin
            if (who != '0 && free_left >= op.want)
            begin
                res.success = 1'b1;
                // lowest free slots first
                for (int i = 0; i < pool_size; i++)
                begin
                    if (slot_tag[i] == '0 && taken < op.want)
                    begin
                        slot_tag[i] = who;
                        taken++;
                    end
                end
                free_left -= taken;
            end
        end
        else if (who != '0)
        begin
            for (int i = 0; i < pool_size; i++)
            begin
                if (slot_tag[i] == who)
                begin
                    slot_tag[i] = '0;
                    free_left++;
                    res.success = 1'b1;
                end
            end
        end
        res.free_units = COUNT_FIELD_W'(free_left);
        return res;
    endfunction

    function automatic bit take_a_break();
        if (cyc >= QUIET_FROM && cyc < QUIET_TO)
            return 1'b0;
        return $urandom_range(99) < 29;
    endfunction

    task automatic report_mismatch(input string msg);
        if (err_cnt < 100)
            $display("ERROR @%0t: %s", $realtime, msg);
        err_cnt++;
    endtask

    task automatic queue_op(input logic command, input logic [OWNER_FIELD_W-1:0] owner,
                            input logic [COUNT_FIELD_W-1:0] want);
        alloc_op_t op;
        op.command = command;
        op.owner   = owner;
        op.want    = want;
        op_q = {op_q, op};
    endtask

    task automatic queue_random_phase(input int n_items);
        logic [OWNER_FIELD_W-1:0] crew [5];
        int                       roll;
        int                       pick;
        foreach (crew[k])
            crew[k] = OWNER_FIELD_W'($urandom_range(65535, 1));
        repeat (n_items)
        begin
            roll = $urandom_range(99);
            pick = $urandom_range(4);
            if (roll < 55)
                queue_op(CMD_REQUEST, crew[pick],
                         COUNT_FIELD_W'(($urandom_range(9) == 0) ? $urandom_range(16)
                                                                 : $urandom_range(4)));
            else if (roll < 85)
                queue_op(CMD_RELEASE, crew[pick], COUNT_FIELD_W'($urandom_range(31)));
            else
                queue_op(1'($urandom_range(1)), OWNER_FIELD_W'($urandom_range(65535)),
                         COUNT_FIELD_W'($urandom_range(31)));
        end
    endtask

    task automatic drain();
        do
            @(posedge clk);
        while (op_q.size() != 0 || grant_q.size() != 0 || cmd.valid);
        // a margin after the last result; scans end before their result is given
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_units(input logic [COUNT_FIELD_W-1:0] units);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.data  <= units;
        do
            @(posedge clk);
        while (!cfg.ready);
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    // sender
    always @(negedge clk)
    begin : drive_cmd
        alloc_op_t next_op;
        if (rst_n)
        begin
            if (!cmd.valid || cmd_fired)
            begin
                cmd_fired = 1'b0;
                if (op_q.size() > 0 && !take_a_break())
                begin
                    next_op = op_q.pop_front();
                    cmd.valid        <= 1'b1;
                    cmd.command      <= next_op.command;
                    cmd.owner_id     <= next_op.owner;
                    cmd.unit_request <= next_op.want;
                end
                else
                    cmd.valid <= 1'b0;
            end
        end
    end

    // receiver, with an optional long hold-off
    always @(negedge clk)
    begin : drive_rsp
        if (rst_n)
        begin
            if (hold_off > 0)
            begin
                hold_off--;
                rsp.ready <= 1'b0;
            end
            else
                rsp.ready <= !take_a_break();
        end
    end

    always @(posedge clk)
    begin : watch
        alloc_op_t  seen;
        alloc_res_t want_res;
        if (rst_n)
        begin
            cyc++;
            if (cfg.valid && cfg.ready)
                pool_resize(cfg.data);
            if (cmd.valid && cmd.ready)
            begin
                seen.command = cmd.command;
                seen.owner   = cmd.owner_id;
                seen.want    = cmd.unit_request;
                grant_q = {grant_q, apply_op(seen)};
                cmd_fired = 1'b1;
            end
            if (rsp.valid && rsp.ready)
            begin
                if (grant_q.size() == 0)
                    report_mismatch("result transfer with nothing outstanding");
                else
                begin
                    want_res = grant_q.pop_front();
                    if (rsp.success !== want_res.success)
                        report_mismatch($sformatf("success %b, expected %b",
                                                  rsp.success, want_res.success));
                    if (rsp.free_units !== want_res.free_units)
                        report_mismatch($sformatf("free_units %0d, expected %0d",
                                                  rsp.free_units, want_res.free_units));
                end
            end
        end
    end

    initial
    begin : watchdog
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : main
        logic [COUNT_FIELD_W-1:0] units;
        rst_n            = 1'b0;
        cmd.valid        = 1'b0;
        cmd.command      = CMD_REQUEST;
        cmd.owner_id     = '0;
        cmd.unit_request = '0;
        rsp.ready        = 1'b0;
        cfg.valid        = 1'b0;
        cfg.data         = '0;
        cmd_fired        = 1'b0;
        hold_off         = 0;
        cyc              = 0;
        err_cnt          = 0;
        pool_resize(COUNT_FIELD_W'(RESET_UNITS));
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // full pool out of reset
        queue_op(CMD_REQUEST, 16'h0000, 5'd0);      // owner zero fails even for nothing
        queue_op(CMD_REQUEST, 16'h0000, 5'd3);
        queue_op(CMD_REQUEST, 16'h0001, 5'd0);      // zero count succeeds
        queue_op(CMD_REQUEST, 16'hFFFF, 5'd16);     // take everything
        queue_op(CMD_REQUEST, 16'h0002, 5'd1);      // pool empty
        queue_op(CMD_RELEASE, 16'h0000, 5'd0);
        queue_op(CMD_RELEASE, 16'h0003, 5'd0);      // no match
        queue_op(CMD_RELEASE, 16'hFFFF, 5'd31);
        queue_op(CMD_REQUEST, 16'h8000, 5'd17);     // more than the pool
        queue_op(CMD_REQUEST, 16'h0005, 5'd31);
        queue_op(CMD_REQUEST, 16'h0005, 5'd5);
        queue_op(CMD_REQUEST, 16'h0006, 5'd3);
        queue_op(CMD_RELEASE, 16'h0005, 5'd0);
        queue_op(CMD_REQUEST, 16'h0007, 5'd6);      // fills the hole, then past owner 6
        queue_op(CMD_RELEASE, 16'h0006, 5'd0);
        queue_op(CMD_RELEASE, 16'h0007, 5'd0);
        queue_op(CMD_REQUEST, 16'hAAAA, 5'd21);
        queue_op(CMD_REQUEST, 16'h5555, 5'd10);
        drain();

        write_units(5'd0);
        queue_op(CMD_REQUEST, 16'h0001, 5'd0);
        queue_op(CMD_REQUEST, 16'h0001, 5'd1);
        queue_op(CMD_RELEASE, 16'h0001, 5'd0);
        drain();

        write_units(5'd31);                          // saturates to a full pool
        queue_op(CMD_REQUEST, 16'h1234, 5'd16);
        drain();

        write_units(5'd1);                           // rewrite while full drops all tags
        queue_op(CMD_REQUEST, 16'h00FF, 5'd1);
        queue_op(CMD_REQUEST, 16'h00FF, 5'd1);
        queue_op(CMD_RELEASE, 16'h00FF, 5'd0);
        drain();

        for (int phase = 0; phase < 10; phase++)
        begin
            case (phase)
                0: units = 5'd16;
                1: units = 5'd3;
                2: units = 5'd31;
                3: units = 5'd0;
                4: units = 5'd8;
                5: units = 5'd1;
                6: units = 5'd16;
                8: units = 5'd12;
                default: units = COUNT_FIELD_W'($urandom_range(31));
            endcase
            write_units(units);
            queue_random_phase(100);
            if (phase == 2)
                hold_off = 300;
            drain();
        end

        if (err_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
